/* rtl/rasa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rasa_pkg
// shared constants and types for the atlas slot allocator
// ----------------------------------------------------------------------------
package rasa_pkg;

  localparam int NUM_CELLS     = 280;
  localparam int FIRST_CELL    = 7;
  localparam int CELLS_PER_ROW = 20;
  localparam int CELL_W        = 100;
  localparam int CELL_H        = 145;
  localparam int CELL_BITS     = $clog2(NUM_CELLS);
  localparam int CNT_BITS      = $clog2(NUM_CELLS + 1);
  localparam int ROW_BITS      = $clog2(NUM_CELLS / CELLS_PER_ROW + 1);
  localparam int COL_BITS      = $clog2(CELLS_PER_ROW);

  localparam logic [15:0] COUNT_MAX = 16'hffff;

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_REL_ALL = 2'd2;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  localparam logic [1:0] IMG_OK   = 2'd1;
  localparam logic [1:0] IMG_FAIL = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_FRESH    = 3'd1;
  localparam logic [2:0] ST_EVICT    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NO_IMAGE = 3'd4;
  localparam logic [2:0] ST_DECODE   = 3'd5;
  localparam logic [2:0] ST_RELEASED = 3'd6;
  localparam logic [2:0] ST_NOT_HELD = 3'd7;

  typedef logic [CELL_BITS-1:0] cell_t;

  typedef struct packed {
    logic [10:0] x;
    logic [10:0] y;
  } pos_t;

endpackage

`default_nettype wire

/* rtl/refcounted_atlas_slot_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_atlas_slot_allocator_unit
// reference counted atlas cell allocator with fresh fifo and lru reclaim list
// ----------------------------------------------------------------------------
// channel  dir  signals
// in       in   in_valid in_ready opcode card_id image_state
// out      out  out_valid out_ready status cell_res atlas_x atlas_y
//                victim_valid victim_id refs_after
// a request or release scans all 280 tags, one per cycle with registered
// reads; when a cell results, the position unit then gives its position.
// release-all walks cells 7 to 279, one per cycle.
// after reset a pass over all 280 cells clears the table and fills the fresh
// fifo; no request is taken meanwhile.
// the result waits in an output register until out_ready; no new request
// is taken until it leaves.
// ----------------------------------------------------------------------------
module refcounted_atlas_slot_allocator_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  opcode,
  input  wire  [31:0] card_id,
  input  wire  [1:0]  image_state,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  status,
  output logic [8:0]  cell_res,
  output logic [10:0] atlas_x,
  output logic [10:0] atlas_y,
  output logic        victim_valid,
  output logic [31:0] victim_id,
  output logic [15:0] refs_after
);
  import rasa_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_RALL  = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_ALLOC = 4'd6;
  localparam logic [3:0] S_POS   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_UNL   = 4'd9;
  localparam logic [3:0] S_UNL2  = 4'd10;
  localparam logic [3:0] S_SCAN2 = 4'd11;
  localparam logic [3:0] S_RALL2 = 4'd12;
  localparam logic [3:0] S_PGO   = 4'd13;

  logic [3:0] state;

  // memories
  logic [15:0] cnt_mem  [NUM_CELLS];
  logic [31:0] tag_mem  [NUM_CELLS];
  logic        hv_mem   [NUM_CELLS];
  cell_t       prev_mem [NUM_CELLS];
  cell_t       next_mem [NUM_CELLS];
  cell_t       fifo_mem [NUM_CELLS];

  logic        rc_ne;
  cell_t       rc_head, rc_tail;
  cell_t       ff_head;
  logic [CNT_BITS-1:0] ff_count;

  logic [1:0]  op;
  logic [31:0] id;
  logic [1:0]  img;
  cell_t       idx, slot, raddr, rd_idx;
  logic        rd_v;
  logic        found;
  logic [15:0] cnt_rd, cnt_hit;
  logic [31:0] tag_rd;
  logic        hv_rd;
  cell_t       prev_rd, next_rd, fifo_rd;
  logic        evicting;

  logic        pos_start, pos_done;
  pos_t        pos;

  rasa_pos u_pos (
    .clk(clk), .rst(rst), .start(pos_start), .slot(slot),
    .done(pos_done), .pos(pos)
  );

  function automatic cell_t inc(cell_t v);
    inc = (v == CELL_BITS'(NUM_CELLS - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic cell_t addm(cell_t a, logic [CNT_BITS-1:0] b);
    logic [CELL_BITS:0] s;
    s = {1'b0, a} + (CELL_BITS + 1)'(b);
    addm = (s >= (CELL_BITS + 1)'(NUM_CELLS)) ? CELL_BITS'(s - NUM_CELLS) : s[CELL_BITS-1:0];
  endfunction

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign pos_start = (state == S_PGO);
  assign raddr     = (state == S_SCAN || state == S_RALL) ? idx : slot;

  // registered reads, walk data arrives in the cycle after its idx
  always_ff @(posedge clk) begin
    cnt_rd  <= cnt_mem[raddr];
    tag_rd  <= tag_mem[raddr];
    hv_rd   <= hv_mem[raddr];
    rd_idx  <= idx;
    rd_v    <= (state == S_SCAN) || (state == S_RALL);
    fifo_rd <= fifo_mem[ff_head];
    prev_rd <= prev_mem[slot];
    next_rd <= next_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
      rc_ne     <= 1'b0;
      ff_head   <= '0;
      ff_count  <= '0;
      idx       <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_INIT: begin
          cnt_mem[idx] <= '0;
          hv_mem[idx]  <= 1'b0;
          if (idx >= CELL_BITS'(FIRST_CELL)) begin
            fifo_mem[CELL_BITS'(idx - FIRST_CELL)] <= idx;
            ff_count <= ff_count + 1'b1;
          end
          if (idx == CELL_BITS'(NUM_CELLS - 1)) state <= S_IDLE;
          else idx <= idx + 1'b1;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= opcode; id <= card_id; img <= image_state;
            found <= 1'b0; evicting <= 1'b0;
            status <= '0; cell_res <= '0; atlas_x <= '0; atlas_y <= '0;
            victim_valid <= 1'b0; victim_id <= '0; refs_after <= '0;
            if (opcode == OP_REL_ALL) begin
              idx <= CELL_BITS'(FIRST_CELL);
              state <= S_RALL;
            end else begin
              idx <= '0;
              if (opcode != OP_UNKNOWN) state <= S_SCAN;
            end
          end
        end
        S_RALL, S_RALL2: begin
          // count read arrives in the cycle after the walk index
          if (rd_v && cnt_rd != '0) begin
            cnt_mem[rd_idx] <= '0;
            if (!rc_ne) begin
              rc_head <= rd_idx; rc_tail <= rd_idx; rc_ne <= 1'b1;
            end else begin
              next_mem[rc_tail] <= rd_idx; prev_mem[rd_idx] <= rc_tail;
              rc_tail <= rd_idx;
            end
          end
          if (state == S_RALL2) begin
            status <= ST_RELEASED; out_valid <= 1'b1; state <= S_IDLE;
          end else if (idx == CELL_BITS'(NUM_CELLS - 1)) state <= S_RALL2;
          else idx <= idx + 1'b1;
        end
        S_SCAN, S_SCAN2: begin
          if (rd_v && !found && hv_rd && tag_rd == id) begin
            found <= 1'b1; slot <= rd_idx; cnt_hit <= cnt_rd;
          end
          if (state == S_SCAN2) state <= S_DEC;
          else if (idx == CELL_BITS'(NUM_CELLS - 1)) state <= S_SCAN2;
          else idx <= idx + 1'b1;
        end
        S_DEC: begin
          if (found) begin
            if (op == OP_RELEASE) begin
              if (cnt_hit == '0) begin
                status <= ST_NOT_HELD; out_valid <= 1'b1; state <= S_IDLE;
              end else begin
                cnt_mem[slot] <= cnt_hit - 1'b1;
                refs_after <= cnt_hit - 1'b1;
                if (cnt_hit == 16'd1) begin
                  if (!rc_ne) begin
                    rc_head <= slot; rc_tail <= slot; rc_ne <= 1'b1;
                  end else begin
                    next_mem[rc_tail] <= slot; prev_mem[slot] <= rc_tail;
                    rc_tail <= slot;
                  end
                end
                status <= ST_RELEASED; state <= S_PGO;
              end
            end else begin
              status <= ST_HIT;
              refs_after <= (cnt_hit == COUNT_MAX) ? cnt_hit : cnt_hit + 1'b1;
              cnt_mem[slot] <= (cnt_hit == COUNT_MAX) ? cnt_hit : cnt_hit + 1'b1;
              if (cnt_hit == '0) state <= S_UNL;
              else state <= S_PGO;
            end
          end else if (op == OP_RELEASE) begin
            status <= ST_NOT_HELD; out_valid <= 1'b1; state <= S_IDLE;
          end else if (img != IMG_OK && img != IMG_FAIL) begin
            status <= ST_NO_IMAGE; out_valid <= 1'b1; state <= S_IDLE;
          end else if (ff_count != '0) begin
            status <= ST_FRESH; state <= S_FRD;
          end else if (rc_ne) begin
            status <= ST_EVICT; slot <= rc_head; evicting <= 1'b1; state <= S_UNL;
          end else begin
            status <= ST_FULL; out_valid <= 1'b1; state <= S_IDLE;
          end
        end
        S_UNL: state <= S_UNL2;  // prev/next and tag read of the cell
        S_UNL2: begin
          if (rc_ne) begin
            if (slot == rc_head && slot == rc_tail) rc_ne <= 1'b0;
            else if (slot == rc_head) rc_head <= next_rd;
            else if (slot == rc_tail) rc_tail <= prev_rd;
            else begin
              next_mem[prev_rd] <= next_rd; prev_mem[next_rd] <= prev_rd;
            end
          end
          if (evicting) begin
            victim_valid <= 1'b1; victim_id <= tag_rd;
            hv_mem[slot] <= 1'b0; state <= S_ALLOC;
          end else begin
            state <= S_PGO;
          end
        end
        S_FRD: begin
          slot     <= fifo_rd;
          ff_head  <= inc(ff_head);
          ff_count <= ff_count - 1'b1;
          state    <= S_ALLOC;
        end
        S_ALLOC: begin
          if (img == IMG_FAIL) begin
            cnt_mem[slot] <= '0; hv_mem[slot] <= 1'b0;
            if (ff_count < CNT_BITS'(NUM_CELLS)) begin
              fifo_mem[addm(ff_head, ff_count)] <= slot;
              ff_count <= ff_count + 1'b1;
            end
            status <= ST_DECODE; out_valid <= 1'b1; state <= S_IDLE;
          end else begin
            cnt_mem[slot] <= 16'd1; tag_mem[slot] <= id; hv_mem[slot] <= 1'b1;
            refs_after <= 16'd1; state <= S_PGO;
          end
        end
        S_PGO: state <= S_POS;
        S_POS: if (pos_done) begin
          cell_res <= 9'(slot); atlas_x <= pos.x; atlas_y <= pos.y;
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_ff_bound: assert property (@(posedge clk) disable iff (rst)
    ff_count <= CNT_BITS'(NUM_CELLS)) else $error("fifo count overflow");
  a_victim_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && victim_valid) |-> (status == ST_EVICT || status == ST_DECODE))
    else $error("victim without eviction");
`endif

endmodule

`default_nettype wire

/* rtl/rasa_pos.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rasa_pos
// cell index to pixel position, one row step per cycle by repeated subtract
// ----------------------------------------------------------------------------
module rasa_pos (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire rasa_pkg::cell_t slot,
  output logic                 done,
  output rasa_pkg::pos_t       pos
);
  import rasa_pkg::*;

  logic              busy;
  cell_t             rem;
  logic [10:0]       ypix;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      rem  <= slot;
      ypix <= '0;
    end else if (busy) begin
      if (rem >= CELL_BITS'(CELLS_PER_ROW)) begin
        rem  <= rem - CELL_BITS'(CELLS_PER_ROW);
        ypix <= ypix + 11'(CELL_H);
      end else begin
        busy  <= 1'b0;
        done  <= 1'b1;
        pos.x <= 11'(rem * CELL_W);
        pos.y <= ypix;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire
